[hw/rtl/rne_pkg.sv]
// Package: shared types, character codes and digit pattern functions of the Roman numeral encoder
`timescale 1ns / 1ps

package rne_pkg;

   localparam int YEAR_WIDTH   = 16;
   localparam int SYMBOL_WIDTH = 8;
   localparam int BCD_DIGITS   = 5;
   localparam int BCD_WIDTH    = 4 * BCD_DIGITS;
   localparam int PLACE_COUNT  = 4;

   localparam logic [SYMBOL_WIDTH-1:0] CHAR_M = 8'h4D;
   localparam logic [SYMBOL_WIDTH-1:0] CHAR_D = 8'h44;
   localparam logic [SYMBOL_WIDTH-1:0] CHAR_C = 8'h43;
   localparam logic [SYMBOL_WIDTH-1:0] CHAR_L = 8'h4C;
   localparam logic [SYMBOL_WIDTH-1:0] CHAR_X = 8'h58;
   localparam logic [SYMBOL_WIDTH-1:0] CHAR_V = 8'h56;
   localparam logic [SYMBOL_WIDTH-1:0] CHAR_I = 8'h49;
   localparam logic [SYMBOL_WIDTH-1:0] CHAR_NONE = 8'h00;

   // digit place codes
   localparam logic [1:0] PLACE_THOUSANDS = 2'd0;
   localparam logic [1:0] PLACE_HUNDREDS  = 2'd1;
   localparam logic [1:0] PLACE_TENS      = 2'd2;
   localparam logic [1:0] PLACE_ONES      = 2'd3;

   typedef enum logic [1:0] {
      KIND_UNIT = 2'd0,
      KIND_FIVE = 2'd1,
      KIND_TEN  = 2'd2
   } symbol_kind_type;

   // digits handed from the splitter to the symbol sequencer
   typedef struct packed {
      logic       bad_year;
      logic [3:0] thousands;   // M count, zero when the year is bad
      logic [3:0] hundreds;
      logic [3:0] tens;
      logic [3:0] ones;
   } digit_set_type;

   function automatic logic [2:0] digit_length(input logic [3:0] d);
      logic [2:0] len;
      begin
         case (d)
            4'd1, 4'd5:             len = 3'd1;
            4'd2, 4'd4, 4'd6, 4'd9: len = 3'd2;
            4'd3, 4'd7:             len = 3'd3;
            4'd8:                   len = 3'd4;
            default:                len = 3'd0;
         endcase
         return len;
      end
   endfunction

   function automatic symbol_kind_type symbol_kind(input logic [3:0] d, input logic [1:0] pos);
      symbol_kind_type kind;
      begin
         if (d == 4'd9) begin
            kind = (pos == 2'd0) ? KIND_UNIT : KIND_TEN;
         end else if (d == 4'd4) begin
            kind = (pos == 2'd0) ? KIND_UNIT : KIND_FIVE;
         end else if (d inside {[4'd5:4'd8]}) begin
            kind = (pos == 2'd0) ? KIND_FIVE : KIND_UNIT;
         end else begin
            kind = KIND_UNIT;
         end
         return kind;
      end
   endfunction

   function automatic logic [SYMBOL_WIDTH-1:0] place_char(input logic [1:0] place,
                                                          input symbol_kind_type kind);
      logic [SYMBOL_WIDTH-1:0] ch;
      begin
         case (place)
            PLACE_THOUSANDS: ch = CHAR_M;
            PLACE_HUNDREDS: begin
               case (kind)
                  KIND_FIVE: ch = CHAR_D;
                  KIND_TEN:  ch = CHAR_M;
                  default:   ch = CHAR_C;
               endcase
            end
            PLACE_TENS: begin
               case (kind)
                  KIND_FIVE: ch = CHAR_L;
                  KIND_TEN:  ch = CHAR_C;
                  default:   ch = CHAR_X;
               endcase
            end
            default: begin
               case (kind)
                  KIND_FIVE: ch = CHAR_V;
                  KIND_TEN:  ch = CHAR_X;
                  default:   ch = CHAR_I;
               endcase
            end
         endcase
         return ch;
      end
   endfunction

endpackage

[hw/rtl/rne_digit_split.sv]
// Bit-serial binary to decimal splitter: shifts the year into a BCD register one bit per cycle
`timescale 1ns / 1ps

module rne_digit_split (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rne_pkg::YEAR_WIDTH-1:0]   year_value,
   output logic                             idle,
   output logic                             digits_valid,
   input  logic                             digits_ready,
   output rne_pkg::digit_set_type           digits
);

   typedef enum logic [2:0] {
      SPLIT_IDLE  = 3'b001,
      SPLIT_SHIFT = 3'b010,
      SPLIT_DONE  = 3'b100
   } split_state_type;

   split_state_type                      state_ff, state_in;
   logic [rne_pkg::YEAR_WIDTH-1:0]       bin_ff, bin_in;
   logic [rne_pkg::BCD_WIDTH-1:0]        bcd_ff, bcd_in;
   logic [3:0]                           count_ff, count_in;
   logic [rne_pkg::BCD_WIDTH-1:0]        bcd_adj;
   logic [3:0]                           upper;
   logic [3:0]                           thou;
   logic                                 good;

   always_comb begin
      for (int i = 0; i < rne_pkg::BCD_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                        : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      case (state_ff)
         SPLIT_IDLE: begin
            if (start) begin
               bin_in   = year_value;
               bcd_in   = '0;
               count_in = '0;
               state_in = SPLIT_SHIFT;
            end
         end
         SPLIT_SHIFT: begin
            bcd_in   = {bcd_adj[rne_pkg::BCD_WIDTH-2:0], bin_ff[rne_pkg::YEAR_WIDTH-1]};
            bin_in   = {bin_ff[rne_pkg::YEAR_WIDTH-2:0], 1'b0};
            count_in = count_ff + 4'd1;
            if (count_ff == 4'd15) begin
               state_in = SPLIT_DONE;
            end
         end
         SPLIT_DONE: begin
            if (digits_ready) begin
               state_in = SPLIT_IDLE;
            end
         end
         default: state_in = SPLIT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SPLIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
   end

   assign upper = bcd_ff[19:16];
   assign thou  = bcd_ff[15:12];
   assign good  = (upper == 4'd0) && (thou inside {[4'd1:4'd3]});

   assign idle         = (state_ff == SPLIT_IDLE);
   assign digits_valid = (state_ff == SPLIT_DONE);

   always_comb begin
      digits.bad_year  = ~good;
      digits.thousands = good ? thou : 4'd0;
      digits.hundreds  = bcd_ff[11:8];
      digits.tens      = bcd_ff[7:4];
      digits.ones      = bcd_ff[3:0];
   end

`ifndef SYNTHESIS
   a_done_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SPLIT_DONE) |-> (bcd_ff[11:8] <= 4'd9 && bcd_ff[7:4] <= 4'd9
                                    && bcd_ff[3:0] <= 4'd9 && bcd_ff[15:12] <= 4'd9))
      else $error("splitter produced a non-decimal digit");
`endif

endmodule

[hw/rtl/rne_symbol_seq.sv]
// Symbol sequencer: walks the four digit places and registers one numeral character per transfer
`timescale 1ns / 1ps

module rne_symbol_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                digits_valid,
   output logic                                digits_ready,
   input  rne_pkg::digit_set_type              digits,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rne_pkg::SYMBOL_WIDTH-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   output logic [1:0]                          rsp_tuser
);

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_RUN  = 2'b10
   } seq_state_type;

   seq_state_type                        state_ff, state_in;
   logic [3:0]                           digit_ff [rne_pkg::PLACE_COUNT];
   logic [3:0]                           digit_in [rne_pkg::PLACE_COUNT];
   logic                                 bad_ff, bad_in;
   logic [1:0]                           place_ff, place_in;
   logic [1:0]                           pos_ff, pos_in;
   logic                                 valid_ff, valid_in;
   logic [rne_pkg::SYMBOL_WIDTH-1:0]     data_ff, data_in;
   logic                                 last_ff, last_in;
   logic [1:0]                           user_ff, user_in;

   logic [3:0]                           cur_digit;
   logic [2:0]                           cur_len;
   logic                                 later_any;
   logic                                 any_digit;
   logic                                 slot_free;
   logic                                 end_of_digit;

   assign slot_free    = ~valid_ff | rsp_tready;
   assign cur_digit    = digit_ff[place_ff];
   assign cur_len      = rne_pkg::digit_length(cur_digit);
   assign end_of_digit = ({1'b0, pos_ff} == cur_len - 3'd1);

   always_comb begin
      later_any = 1'b0;
      any_digit = 1'b0;
      for (int i = 0; i < rne_pkg::PLACE_COUNT; i++) begin
         if (digit_ff[i] != 4'd0) begin
            any_digit = 1'b1;
            if (i > int'(place_ff)) begin
               later_any = 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      digit_in = digit_ff;
      bad_in   = bad_ff;
      place_in = place_ff;
      pos_in   = pos_ff;
      valid_in = rsp_tready ? 1'b0 : valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      user_in  = user_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (digits_valid) begin
               digit_in[0] = digits.thousands;
               digit_in[1] = digits.hundreds;
               digit_in[2] = digits.tens;
               digit_in[3] = digits.ones;
               bad_in      = digits.bad_year;
               place_in    = rne_pkg::PLACE_THOUSANDS;
               pos_in      = 2'd0;
               state_in    = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (!any_digit) begin
               // empty numeral
               if (slot_free) begin
                  valid_in = 1'b1;
                  data_in  = rne_pkg::CHAR_NONE;
                  last_in  = 1'b1;
                  user_in  = {1'b1, bad_ff};
                  state_in = SEQ_IDLE;
               end
            end else if (cur_digit == 4'd0) begin
               place_in = place_ff + 2'd1;
               pos_in   = 2'd0;
            end else if (slot_free) begin
               valid_in = 1'b1;
               data_in  = rne_pkg::place_char(place_ff,
                                              rne_pkg::symbol_kind(cur_digit, pos_ff));
               last_in  = end_of_digit & ~later_any;
               user_in  = {1'b0, bad_ff};
               if (end_of_digit) begin
                  pos_in   = 2'd0;
                  place_in = place_ff + 2'd1;
                  if (!later_any) begin
                     state_in = SEQ_IDLE;
                  end
               end else begin
                  pos_in = pos_ff + 2'd1;
               end
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      digit_ff <= digit_in;
      bad_ff   <= bad_in;
      place_ff <= place_in;
      pos_ff   <= pos_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
      user_ff  <= user_in;
   end

   assign digits_ready = (state_ff == SEQ_IDLE);
   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = data_ff;
   assign rsp_tlast    = last_ff;
   assign rsp_tuser    = user_ff;

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && user_ff[1]) |-> (last_ff && data_ff == rne_pkg::CHAR_NONE))
      else $error("empty numeral transfer not marked last");
   a_no_emit_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_IDLE && !valid_ff) |=> !valid_ff || $past(digits_valid) == 1'b0)
      else $error("transfer emitted while sequencer idle");
`endif

endmodule

[hw/rtl/roman_numeral_encoder_unit.sv]
// Top level of the Roman numeral encoder: year in, one ASCII numeral character per transfer out
`timescale 1ns / 1ps

// A year on req_tdata is converted to its Roman numeral, sent as one character per rsp
// transfer in reading order with rsp_tlast on the final one. rsp_tuser[0] flags a thousands
// count other than 1 to 3 (no M is sent then); rsp_tuser[1] marks a single empty transfer
// when no character results. The decimal split is a bit-serial shift-and-adjust over the 16
// year bits: the year is loaded, shifted in bit by bit, and the digits are then held until the
// sequencer takes them; req_tready returns only after that hand-over. Characters then leave
// one per cycle while rsp_tready is high, with a gap for every zero digit place met before the
// last nonzero one; an empty numeral is a single transfer. The next year is split while the
// current one is sent, but its digits are taken only once the current numeral is done; a
// numeral has at most 15 characters.

module roman_numeral_encoder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rne_pkg::YEAR_WIDTH-1:0]      req_tdata,   // [15:0] year_value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rne_pkg::SYMBOL_WIDTH-1:0]    rsp_tdata,   // [7:0] symbol
   output logic                                rsp_tlast,   // is_last
   output logic [1:0]                          rsp_tuser    // [0] bad_year, [1] no_symbol
);

   logic                     split_idle;
   logic                     digits_valid;
   logic                     digits_ready;
   rne_pkg::digit_set_type   digits;

   assign req_tready = split_idle;

   rne_digit_split u_split (
      .clock        (clock),
      .reset        (reset),
      .start        (req_tvalid & req_tready),
      .year_value   (req_tdata),
      .idle         (split_idle),
      .digits_valid (digits_valid),
      .digits_ready (digits_ready),
      .digits       (digits)
   );

   rne_symbol_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .digits_valid (digits_valid),
      .digits_ready (digits_ready),
      .digits       (digits),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule
